FILE: rtl/radix_integer_to_ascii_assert.svh
// Assertion macros for the integer to text converter.
`ifndef RADIX_INTEGER_TO_ASCII_ASSERT_SVH
`define RADIX_INTEGER_TO_ASCII_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RITA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RITA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rita_pkg.sv
`default_nettype none

package rita_pkg;

    localparam int VALUE_W        = 64;
    localparam int BASE_W         = 6;
    localparam int CHAR_W         = 7;
    localparam int DCOUNT_W       = 7;
    localparam int M_TDATA_W      = 16;
    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_DIGITS = 64;

    localparam logic [BASE_W-1:0] BASE_RESET    = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_MIN      = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX      = BASE_W'(36);
    localparam logic [BASE_W-1:0] DECIMAL_LIMIT = BASE_W'(10);
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = CHAR_W'(65);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_FETCH,
        ST_SEND
    } rita_state_t;

    function automatic logic [BASE_W-1:0] effective_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_LIMIT) begin
            c = CHAR_ZERO + {1'b0, d};
        end else begin
            c = CHAR_UPPER_A - {1'b0, DECIMAL_LIMIT} + {1'b0, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rita_divider.sv
`default_nettype none

module rita_divider
    import rita_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [BASE_W-1:0]     divisor,
    output logic                       done,
    output logic [VALUE_BITS-1:0]      quotient,
    output logic [BASE_W-1:0]          remainder
);

    localparam int STEP_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [BASE_W-1:0]     rem_reg, rem_next;
    logic [BASE_W:0]       trial;
    logic                  fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
        fits      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(VALUE_BITS - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[VALUE_BITS-2:0], fits};
            rem_next  = fits ? BASE_W'(trial - {1'b0, divisor}) : BASE_W'(trial);
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/rita_digit_store.sv
`default_nettype none

module rita_digit_store
    import rita_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(MAX_DIGITS)-1:0] wr_addr,
    input  wire logic [BASE_W-1:0]             wr_data,
    input  wire logic [$clog2(MAX_DIGITS)-1:0] rd_addr,
    output logic [BASE_W-1:0]                  rd_data
);

    logic [BASE_W-1:0] mem [MAX_DIGITS];
    logic [BASE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/radix_integer_to_ascii.sv
// Channel  Direction  Ports                                   Word
// input    in         s_tvalid s_tready s_tdata               value
// result   out        m_tvalid m_tready m_tdata m_tlast       digit_char, digit_count
// config   in         cfg_wr_en cfg_wr_data                   number_base
//
// Each digit comes from the one-bit-per-cycle restoring divider.
// Each character then passes a digit store read and a present step, plus any stall.
// While a value is converted and sent, s_tready is low.
// Reset (aresetn low, synchronous) sets number_base to 10 and returns to idle.
// m_tready low holds the current character; no further input is taken meanwhile.
`default_nettype none

`include "radix_integer_to_ascii_assert.svh"

module radix_integer_to_ascii
    import rita_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [VALUE_W-1:0]   s_tdata,     // [63:0] value
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,     // [6:0] digit_char, [13:7] digit_count
    output logic                      m_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic [BASE_W-1:0]    cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    rita_state_t           state_reg, state_next;
    logic [BASE_W-1:0]     base_reg;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]      count_inc;

    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [BASE_W-1:0]     div_remainder;
    logic                  store_wr_en;
    logic [BASE_W-1:0]     store_rd_data;

    rita_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (quo_reg),
        .divisor   (effective_base(base_reg)),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    rita_digit_store #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_digit_store (
        .aclk    (aclk),
        .wr_en   (store_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (div_remainder),
        .rd_addr (rd_idx_reg),
        .rd_data (store_rd_data)
    );

    always_comb begin
        state_next  = state_reg;
        quo_next    = quo_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        count_inc   = count_reg + CNT_W'(1);
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        div_start   = 1'b0;
        store_wr_en = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    quo_next   = s_tdata[VALUE_BITS-1:0];
                    count_next = '0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    store_wr_en = 1'b1;
                    quo_next    = div_quotient;
                    count_next  = count_inc;
                    rd_idx_next = count_reg[IDX_W-1:0];
                    if (div_quotient != '0 && count_inc < CNT_W'(MAX_DIGITS)) begin
                        state_next = ST_START;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (rd_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                        state_next  = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            base_reg  <= BASE_RESET;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
        end
        quo_reg    <= quo_next;
        rd_idx_reg <= rd_idx_next;
    end

    assign m_tdata = {{(M_TDATA_W - CHAR_W - DCOUNT_W){1'b0}},
                      DCOUNT_W'(count_reg), digit_to_char(store_rd_data)};
    assign m_tlast = (rd_idx_reg == '0);

    `RITA_ASSERT_NOW(a_one_side_busy, m_tvalid, !s_tready, "input taken while sending")
    `RITA_ASSERT_NOW(a_done_in_div, div_done, state_reg == ST_DIV, "divider done outside wait")
    `RITA_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_START, "no start")
    `RITA_ASSERT_NOW(a_send_has_digits, m_tvalid, count_reg != '0, "sending with no digits")

endmodule

`default_nettype wire
